// ----- src/mlg_pkg.sv -----
package mlg_pkg;

   // canvas geometry and stop storage
   localparam int SIDE      = 256;
   localparam int CANVAS    = 363;
   localparam int MAX_STOPS = 8;

   localparam int ROW_W      = 9;
   localparam int CHAN_W     = 8;
   localparam int MP_W       = 7;
   localparam int OPACITY_W  = 9;
   localparam int COUNT_W    = 4;
   localparam int STOP_REGS  = 4;
   localparam int STOP_REG_W = 64;
   localparam int WORD_W     = 32;
   localparam int STOP_SEL_W = $clog2(2 * STOP_REGS);

   localparam int MP_MAX      = 100;
   localparam int OPACITY_MAX = 256;

   // register indexes of the csr port, the last index lies outside the map
   localparam int                    CSR_ADDR_W     = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIDPOINT   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_OPACITY    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_STOP_COUNT = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_STOPS_0_1  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_STOPS_2_3  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_STOPS_4_5  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_STOPS_6_7  = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE      = 3'd7;

   // q0.16 position, one extra bit to hold 1.0
   localparam int FRAC_BITS = 16;
   localparam int REL_W     = FRAC_BITS + 1;
   localparam int REL_ONE   = 1 << FRAC_BITS;

   // band height and half-row arithmetic
   localparam int BAND_W = $clog2(SIDE + 1);
   localparam int DEN_W  = $clog2(2 * SIDE);
   localparam int NUM_W  = $clog2(CANVAS + SIDE + 2 ** (ROW_W + 1)) + 1;

   // divide by 100 as multiply by reciprocal
   localparam int X_W         = $clog2(MP_MAX * SIDE + MP_MAX / 2 + 1);
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP       = (2 ** RECIP_SHIFT + MP_MAX - 1) / MP_MAX;
   localparam int RECIP_W     = $clog2(RECIP + 1);

   // long division pipeline
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = FRAC_BITS / DIV_STEPS;

   // blending
   localparam int IDX_W       = $clog2(MAX_STOPS);
   localparam int ACC_W       = CHAN_W + FRAC_BITS;
   localparam int OPACITY_FRAC = 8;
   localparam int ALPHA_SHIFT = FRAC_BITS + OPACITY_FRAC;

   typedef struct packed {
      logic [MP_W-1:0]                        midpoint;
      logic [OPACITY_W-1:0]                   opacity;
      logic [COUNT_W-1:0]                     stop_count;
      logic [STOP_REGS-1:0][STOP_REG_W-1:0]   stops;
   } cfg_type;

   // one item on its way through the divider
   typedef struct packed {
      logic                 need_div;
      logic [REL_W-1:0]     fixed_rel;
      logic [DEN_W-1:0]     rem;
      logic [DEN_W-1:0]     den;
      logic [FRAC_BITS-1:0] low_bits;
      logic [FRAC_BITS-1:0] quo;
   } div_type;

   // red in the lowest byte
   typedef struct packed {
      logic [CHAN_W-1:0] alpha;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } color_type;

   function automatic logic [WORD_W-1:0] stop_word(
      input logic [STOP_REGS-1:0][STOP_REG_W-1:0] stops,
      input logic [STOP_SEL_W-1:0]                k
   );
      return stops[k[STOP_SEL_W-1:1]][k[0]*WORD_W +: WORD_W];
   endfunction

endpackage

// ----- src/mlg_pos.sv -----
module mlg_pos (
   input  logic                       clock,
   input  logic                       reset,
   input  mlg_pkg::cfg_type           cfg,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [mlg_pkg::ROW_W-1:0]  in_row,
   output logic                       out_valid,
   input  logic                       out_ready,
   output mlg_pkg::div_type           out_data
);

   localparam int PROD_W = mlg_pkg::X_W + mlg_pkg::RECIP_W;

   // stage 1: band height
   logic [mlg_pkg::MP_W-1:0]   mp_sat;
   logic [mlg_pkg::X_W-1:0]    x_w;
   logic [PROD_W-1:0]          prod_w;
   logic [mlg_pkg::BAND_W-1:0] band_raw;
   logic [mlg_pkg::BAND_W-1:0] band_in;
   logic [mlg_pkg::BAND_W-1:0] band_ff;
   logic [mlg_pkg::ROW_W-1:0]  row_ff;
   logic                       s1_valid_ff;
   logic                       s1_ready;

   // stage 2: position in half rows
   logic signed [mlg_pkg::NUM_W-1:0] fs2_w;
   logic signed [mlg_pkg::NUM_W-1:0] num_w;
   logic signed [mlg_pkg::NUM_W-1:0] den_s;
   logic [mlg_pkg::DEN_W-1:0]        den_w;
   logic                             step_w;
   logic                             at_one;
   mlg_pkg::div_type                 data_in;
   mlg_pkg::div_type                 data_ff;
   logic                             s2_valid_ff;
   logic                             s2_ready;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      mp_sat = (cfg.midpoint > mlg_pkg::MP_W'(mlg_pkg::MP_MAX)) ?
               mlg_pkg::MP_W'(mlg_pkg::MP_MAX) : cfg.midpoint;
      x_w = mlg_pkg::X_W'(mp_sat) * mlg_pkg::X_W'(mlg_pkg::SIDE)
            + mlg_pkg::X_W'(mlg_pkg::MP_MAX / 2);
      prod_w = PROD_W'(x_w) * PROD_W'(mlg_pkg::RECIP);
      band_raw = mlg_pkg::BAND_W'(prod_w >> mlg_pkg::RECIP_SHIFT);
      band_in = (band_raw == '0) ? mlg_pkg::BAND_W'(1) : band_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         band_ff <= band_in;
         row_ff  <= in_row;
      end
   end

   always_comb begin
      fs2_w  = mlg_pkg::NUM_W'(mlg_pkg::CANVAS + mlg_pkg::SIDE)
               - (mlg_pkg::NUM_W'(band_ff) << 1);
      num_w  = (mlg_pkg::NUM_W'(row_ff) << 1) - fs2_w;
      den_w  = mlg_pkg::DEN_W'({band_ff - mlg_pkg::BAND_W'(1), 1'b0});
      den_s  = mlg_pkg::NUM_W'(den_w);
      step_w = (band_ff == mlg_pkg::BAND_W'(1));
      // a one-row band is a step that already counts the start row as inside
      at_one = step_w ? (num_w >= 0) : (num_w > 0);

      data_in.need_div  = !step_w && (num_w > 0) && (num_w < den_s);
      data_in.fixed_rel = at_one ? mlg_pkg::REL_W'(mlg_pkg::REL_ONE) : '0;
      data_in.rem       = mlg_pkg::DEN_W'(num_w);
      data_in.den       = den_w;
      data_in.low_bits  = mlg_pkg::FRAC_BITS'(band_ff - mlg_pkg::BAND_W'(1));
      data_in.quo       = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- src/mlg_div.sv -----
module mlg_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  mlg_pkg::div_type           in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [mlg_pkg::REL_W-1:0]  out_rel
);

   localparam int LAST = mlg_pkg::DIV_STAGES - 1;

   mlg_pkg::div_type stage_ff    [mlg_pkg::DIV_STAGES];
   logic             valid_ff    [mlg_pkg::DIV_STAGES];
   logic             stage_ready [mlg_pkg::DIV_STAGES];

   for (genvar s = 0; s < mlg_pkg::DIV_STAGES; s++) begin : g_stage
      mlg_pkg::div_type src;
      mlg_pkg::div_type nxt_in;
      logic             src_valid;
      logic             down_ready;

      if (s == 0) begin : g_first
         assign src       = in_data;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src       = stage_ff[s-1];
         assign src_valid = valid_ff[s-1];
      end

      if (s == LAST) begin : g_tail
         assign down_ready = out_ready;
      end else begin : g_body
         assign down_ready = stage_ready[s+1];
      end

      assign stage_ready[s] = !valid_ff[s] || down_ready;

      // restoring division, a few quotient bits per stage
      always_comb begin
         logic [mlg_pkg::DEN_W:0] r2;
         nxt_in = src;
         for (int j = 0; j < mlg_pkg::DIV_STEPS; j++) begin
            r2 = {nxt_in.rem,
                  nxt_in.low_bits[mlg_pkg::FRAC_BITS - 1 - s * mlg_pkg::DIV_STEPS - j]};
            if (r2 >= {1'b0, nxt_in.den}) begin
               nxt_in.rem = mlg_pkg::DEN_W'(r2 - {1'b0, nxt_in.den});
               nxt_in.quo = {nxt_in.quo[mlg_pkg::FRAC_BITS-2:0], 1'b1};
            end else begin
               nxt_in.rem = r2[mlg_pkg::DEN_W-1:0];
               nxt_in.quo = {nxt_in.quo[mlg_pkg::FRAC_BITS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (stage_ready[s]) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[s]) begin
            stage_ff[s] <= nxt_in;
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[LAST];
   assign out_rel   = stage_ff[LAST].need_div ? {1'b0, stage_ff[LAST].quo}
                                              : stage_ff[LAST].fixed_rel;

endmodule

// ----- src/mlg_blend.sv -----
module mlg_blend (
   input  logic                       clock,
   input  logic                       reset,
   input  mlg_pkg::cfg_type           cfg,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [mlg_pkg::REL_W-1:0]  in_rel,
   output logic                       out_valid,
   input  logic                       out_ready,
   output mlg_pkg::color_type         out_color
);

   localparam int POS_W  = mlg_pkg::REL_W + mlg_pkg::IDX_W;
   localparam int MUL_W  = mlg_pkg::ACC_W + 1;
   localparam int APROD_W = mlg_pkg::ACC_W + mlg_pkg::OPACITY_W;
   localparam int CHANS  = 4;

   // stage 1: segment and fraction
   logic [mlg_pkg::COUNT_W-1:0] n_w;
   logic [mlg_pkg::IDX_W-1:0]   seg_w;
   logic [mlg_pkg::IDX_W-1:0]   seg_last;
   logic [POS_W-1:0]            pos_w;
   logic [mlg_pkg::IDX_W:0]     idx_raw;
   logic [mlg_pkg::IDX_W-1:0]   idx_in;
   logic [mlg_pkg::REL_W-1:0]   frac_in;
   logic                        multi_in;
   logic [mlg_pkg::IDX_W-1:0]   idx_ff;
   logic [mlg_pkg::REL_W-1:0]   frac1_ff;
   logic                        multi_ff;
   logic                        v1_ff;
   logic                        r1;

   // stage 2: stop words
   logic [mlg_pkg::STOP_SEL_W-1:0] k1;
   logic [mlg_pkg::STOP_SEL_W-1:0] k2;
   logic [mlg_pkg::WORD_W-1:0]     w1_in;
   logic [mlg_pkg::WORD_W-1:0]     w2_in;
   logic [mlg_pkg::WORD_W-1:0]     w1_ff;
   logic [mlg_pkg::WORD_W-1:0]     w2_ff;
   logic [mlg_pkg::REL_W-1:0]      frac2_ff;
   logic                           v2_ff;
   logic                           r2;

   // stage 3: weighted sums
   logic [mlg_pkg::REL_W-1:0] inv_w;
   logic [mlg_pkg::ACC_W-1:0] acc_in [CHANS];
   logic [mlg_pkg::ACC_W-1:0] acc_ff [CHANS];
   logic                      v3_ff;
   logic                      r3;

   // stage 4: rounding and opacity
   logic [mlg_pkg::OPACITY_W-1:0] op_sat;
   logic [APROD_W-1:0]            aprod_w;
   logic [mlg_pkg::OPACITY_W-1:0] alpha_w;
   logic [mlg_pkg::CHAN_W-1:0]    rgb_w [3];
   mlg_pkg::color_type            color_in;
   mlg_pkg::color_type            color_ff;
   logic                          v4_ff;
   logic                          r4;

   assign r4 = !v4_ff || out_ready;
   assign r3 = !v3_ff || r4;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign in_ready = r1;

   always_comb begin
      if (cfg.stop_count == '0) begin
         n_w = mlg_pkg::COUNT_W'(1);
      end else if (cfg.stop_count > mlg_pkg::COUNT_W'(mlg_pkg::MAX_STOPS)) begin
         n_w = mlg_pkg::COUNT_W'(mlg_pkg::MAX_STOPS);
      end else begin
         n_w = cfg.stop_count;
      end
      multi_in = (n_w > mlg_pkg::COUNT_W'(1));
      seg_w    = multi_in ? mlg_pkg::IDX_W'(n_w - mlg_pkg::COUNT_W'(1))
                          : mlg_pkg::IDX_W'(1);
      seg_last = seg_w - mlg_pkg::IDX_W'(1);
      pos_w    = POS_W'(in_rel) * POS_W'(seg_w);
      idx_raw  = pos_w[POS_W-1:mlg_pkg::FRAC_BITS];
      // the top end lands on the last segment with a full fraction
      idx_in   = (idx_raw > {1'b0, seg_last}) ? seg_last : idx_raw[mlg_pkg::IDX_W-1:0];
      frac_in  = mlg_pkg::REL_W'(pos_w - POS_W'({idx_in, mlg_pkg::FRAC_BITS'(0)}));
   end

   always_comb begin
      k1    = mlg_pkg::STOP_SEL_W'(idx_ff);
      k2    = k1 + mlg_pkg::STOP_SEL_W'(1);
      w1_in = mlg_pkg::stop_word(cfg.stops, k1);
      w2_in = multi_ff ? mlg_pkg::stop_word(cfg.stops, k2) : w1_in;
   end

   always_comb begin
      inv_w = mlg_pkg::REL_W'(mlg_pkg::REL_ONE) - frac2_ff;
      for (int c = 0; c < CHANS; c++) begin
         acc_in[c] = mlg_pkg::ACC_W'(
            MUL_W'(w1_ff[c*mlg_pkg::CHAN_W +: mlg_pkg::CHAN_W]) * MUL_W'(inv_w)
            + MUL_W'(w2_ff[c*mlg_pkg::CHAN_W +: mlg_pkg::CHAN_W]) * MUL_W'(frac2_ff));
      end
   end

   always_comb begin
      op_sat = (cfg.opacity > mlg_pkg::OPACITY_W'(mlg_pkg::OPACITY_MAX)) ?
               mlg_pkg::OPACITY_W'(mlg_pkg::OPACITY_MAX) : cfg.opacity;
      for (int c = 0; c < 3; c++) begin
         rgb_w[c] = mlg_pkg::CHAN_W'((MUL_W'(acc_ff[c])
                    + MUL_W'(1 << (mlg_pkg::FRAC_BITS - 1))) >> mlg_pkg::FRAC_BITS);
      end
      aprod_w = APROD_W'(acc_ff[3]) * APROD_W'(op_sat);
      alpha_w = mlg_pkg::OPACITY_W'((aprod_w + APROD_W'(1 << (mlg_pkg::ALPHA_SHIFT - 1)))
                >> mlg_pkg::ALPHA_SHIFT);
      color_in.red   = rgb_w[0];
      color_in.green = rgb_w[1];
      color_in.blue  = rgb_w[2];
      color_in.alpha = alpha_w[mlg_pkg::OPACITY_W-1] ? '1 : alpha_w[mlg_pkg::CHAN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) begin
            v1_ff <= in_valid;
         end
         if (r2) begin
            v2_ff <= v1_ff;
         end
         if (r3) begin
            v3_ff <= v2_ff;
         end
         if (r4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         idx_ff   <= idx_in;
         frac1_ff <= frac_in;
         multi_ff <= multi_in;
      end
      if (r2) begin
         w1_ff    <= w1_in;
         w2_ff    <= w2_in;
         frac2_ff <= frac1_ff;
      end
      if (r3) begin
         acc_ff <= acc_in;
      end
      if (r4) begin
         color_ff <= color_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_color = color_ff;

endmodule

// ----- src/multi_stop_linear_gradient_row_color.sv -----
// channel   dir   transfer when             payload
// req_      in    req_tvalid & req_tready   tdata: row
// rsp_      out   rsp_tvalid & rsp_tready   tdata: red, green, blue, alpha
// csr_      in    csr_we                    csr_addr selects register, csr_wdata
//
// one row per cycle when the result side keeps up; the pipeline is made of
// 2 position stages, 8 divider stages at 2 quotient bits each and 4 blend stages
// the long division of the band position sets the depth of the pipeline
// synchronous active-high reset clears every stage valid and loads register defaults
// each stage loads when it is empty or its successor moves, so bubbles close up
// and input is still taken while the output register holds a result, if a stage is empty
module multi_stop_linear_gradient_row_color (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [8:0] row

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha

   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);

   mlg_pkg::cfg_type cfg_ff;

   // position stage to divider
   logic             pos_valid;
   logic             pos_ready;
   mlg_pkg::div_type pos_data;

   // divider to blend
   logic                      rel_valid;
   logic                      rel_ready;
   logic [mlg_pkg::REL_W-1:0] rel;

   mlg_pkg::color_type color;

   // config writes; the user keeps the block idle when these come in, it is not enforced
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.midpoint   <= mlg_pkg::MP_W'(mlg_pkg::MP_MAX);
         cfg_ff.opacity    <= mlg_pkg::OPACITY_W'(mlg_pkg::OPACITY_MAX);
         cfg_ff.stop_count <= mlg_pkg::COUNT_W'(2);
         cfg_ff.stops      <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            mlg_pkg::CSR_MIDPOINT:   cfg_ff.midpoint   <= csr_wdata[mlg_pkg::MP_W-1:0];
            mlg_pkg::CSR_OPACITY:    cfg_ff.opacity    <= csr_wdata[mlg_pkg::OPACITY_W-1:0];
            mlg_pkg::CSR_STOP_COUNT: cfg_ff.stop_count <= csr_wdata[mlg_pkg::COUNT_W-1:0];
            mlg_pkg::CSR_STOPS_0_1:  cfg_ff.stops[0]   <= csr_wdata;
            mlg_pkg::CSR_STOPS_2_3:  cfg_ff.stops[1]   <= csr_wdata;
            mlg_pkg::CSR_STOPS_4_5:  cfg_ff.stops[2]   <= csr_wdata;
            mlg_pkg::CSR_STOPS_6_7:  cfg_ff.stops[3]   <= csr_wdata;
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   // band height from midpoint, then row offset against the band in half rows
   mlg_pos u_pos (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_row    (req_tdata[mlg_pkg::ROW_W-1:0]),
      .out_valid (pos_valid),
      .out_ready (pos_ready),
      .out_data  (pos_data)
   );

   // relative position as q0.16, rounded half up
   mlg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pos_valid),
      .in_ready  (pos_ready),
      .in_data   (pos_data),
      .out_valid (rel_valid),
      .out_ready (rel_ready),
      .out_rel   (rel)
   );

   // segment pick, stop lookup, interpolation, opacity; last stage is the output register
   mlg_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (rel_valid),
      .in_ready  (rel_ready),
      .in_rel    (rel),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_color (color)
   );

   assign rsp_tdata = color;

   // a row sent to the divider must already sit below the divisor
   a_div_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      pos_valid && pos_data.need_div |-> pos_data.rem < pos_data.den)
      else $error("divider entry remainder not below divisor");

   // relative position never exceeds 1.0
   a_rel_in_range: assert property (@(posedge clock) disable iff (reset)
      rel_valid |-> rel <= mlg_pkg::REL_W'(mlg_pkg::REL_ONE))
      else $error("relative position above one");

   // input only backs up when every stage is full behind a stalled output
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled while the pipeline has room");

endmodule

// ----- tb/sv/multi_stop_linear_gradient_row_color_tb.sv -----
`timescale 1ns / 1ps

module multi_stop_linear_gradient_row_color_tb;

   typedef enum logic {STEP_WRITE, STEP_ROW} step_kind_type;

   // one line of the directed table
   typedef struct {
      step_kind_type                     kind;
      logic [mlg_pkg::CSR_ADDR_W-1:0]    addr;
      logic [63:0]                       data;
      logic [mlg_pkg::ROW_W-1:0]         row;
      bit                                typed;
      mlg_pkg::color_type                want;
   } plan_step_type;

   // one expected row color, in transfer order
   typedef struct {
      logic [mlg_pkg::ROW_W-1:0] row;
      mlg_pkg::color_type        color;
   } row_color_type;

   localparam int LATENCY        = 14;
   localparam int RANDOM_ROWS    = 1300;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int CW             = mlg_pkg::CHAN_W;

   // stop colors for the directed part, red in the low byte
   localparam logic [mlg_pkg::WORD_W-1:0] S0 = 32'hFF302010;
   localparam logic [mlg_pkg::WORD_W-1:0] S1 = 32'h80C0E0F0;
   localparam logic [mlg_pkg::WORD_W-1:0] S2 = 32'h01020304;
   localparam logic [mlg_pkg::WORD_W-1:0] S3 = 32'h7F7F7F7F;
   localparam logic [mlg_pkg::WORD_W-1:0] S4 = 32'h00FF00FF;
   localparam logic [mlg_pkg::WORD_W-1:0] S5 = 32'hFF00FF00;
   localparam logic [mlg_pkg::WORD_W-1:0] S6 = 32'h12345678;
   localparam logic [mlg_pkg::WORD_W-1:0] S7 = 32'hEDCBA987;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;      // [8:0] row
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_addr   = '0;
   logic [63:0] csr_wdata  = '0;

   // shadow copy of the registers, as the block should hold them
   logic [mlg_pkg::MP_W-1:0]       set_midpoint = mlg_pkg::MP_W'(mlg_pkg::MP_MAX);
   logic [mlg_pkg::OPACITY_W-1:0]  set_opacity  = mlg_pkg::OPACITY_W'(mlg_pkg::OPACITY_MAX);
   logic [mlg_pkg::COUNT_W-1:0]    set_count    = mlg_pkg::COUNT_W'(2);
   logic [mlg_pkg::STOP_REG_W-1:0] set_stops [mlg_pkg::STOP_REGS] = '{default: '0};

   row_color_type pending_colors[$];
   plan_step_type plan[$];
   string         chan_name[4] = '{"red", "green", "blue", "alpha"};

   int errors       = 0;
   int rows_sent    = 0;
   int quiet_cycles = 0;
   bit req_steady   = 1'b0;
   bit rsp_steady   = 1'b0;
   bit hold_output  = 1'b0;

   multi_stop_linear_gradient_row_color i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [mlg_pkg::WORD_W-1:0] stop_at(longint k);
      logic [mlg_pkg::STOP_REG_W-1:0] pair;
      pair = set_stops[int'(k / 2)];
      return k[0] ? pair[2*mlg_pkg::WORD_W-1:mlg_pkg::WORD_W] : pair[mlg_pkg::WORD_W-1:0];
   endfunction

   // color of one canvas row under the current shadow registers
   function automatic mlg_pkg::color_type row_color(logic [mlg_pkg::ROW_W-1:0] row);
      longint mp, op, n, band, start2, num, den, rel, seg, pos, idx, frac, acc;
      logic [mlg_pkg::WORD_W-1:0] lo_word, hi_word;
      mlg_pkg::color_type c;
      mp = (set_midpoint > mlg_pkg::MP_MAX) ? mlg_pkg::MP_MAX : set_midpoint;
      op = (set_opacity > mlg_pkg::OPACITY_MAX) ? mlg_pkg::OPACITY_MAX : set_opacity;
      n  = set_count;
      if (n < 1) n = 1;
      if (n > mlg_pkg::MAX_STOPS) n = mlg_pkg::MAX_STOPS;

      band = (mp * mlg_pkg::SIDE + mlg_pkg::MP_MAX / 2) / mlg_pkg::MP_MAX;
      if (band < 1) band = 1;

      // band start in half rows keeps the centering offset exact
      start2 = (mlg_pkg::CANVAS - mlg_pkg::SIDE) + 2 * (mlg_pkg::SIDE - band);
      num    = 2 * longint'(row) - start2;

      if (band == 1) begin
         // one-row band is a hard step
         rel = (num >= 0) ? mlg_pkg::REL_ONE : 0;
      end else begin
         den = 2 * (band - 1);
         if (num <= 0) rel = 0;
         else if (num >= den) rel = mlg_pkg::REL_ONE;
         else rel = (num * mlg_pkg::REL_ONE + (band - 1)) / den;
      end

      seg = (n > 1) ? n - 1 : 1;
      pos = rel * seg;
      idx = pos >> mlg_pkg::FRAC_BITS;
      if (idx > seg - 1) idx = seg - 1;
      frac = pos - (idx << mlg_pkg::FRAC_BITS);

      lo_word = stop_at(idx);
      hi_word = (n > 1) ? stop_at(idx + 1) : lo_word;

      for (int ch = 0; ch < 3; ch++) begin
         acc = longint'(lo_word[ch*CW +: CW]) * (mlg_pkg::REL_ONE - frac)
             + longint'(hi_word[ch*CW +: CW]) * frac + (mlg_pkg::REL_ONE / 2);
         c[ch*CW +: CW] = CW'(acc >> mlg_pkg::FRAC_BITS);
      end
      // alpha blends first, then takes the opacity scale with one rounding
      acc = longint'(lo_word[3*CW +: CW]) * (mlg_pkg::REL_ONE - frac)
          + longint'(hi_word[3*CW +: CW]) * frac;
      acc = (acc * op + (longint'(1) << (mlg_pkg::ALPHA_SHIFT - 1))) >> mlg_pkg::ALPHA_SHIFT;
      if (acc > 255) acc = 255;
      c.alpha = CW'(acc);
      return c;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_gap(bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [mlg_pkg::ROW_W-1:0] pick_row();
      if ($urandom_range(0, 99) < 85) begin
         return mlg_pkg::ROW_W'($urandom_range(0, mlg_pkg::CANVAS - 1));
      end
      return mlg_pkg::ROW_W'($urandom_range(0, 2 ** mlg_pkg::ROW_W - 1));
   endfunction

   task automatic plan_write(logic [mlg_pkg::CSR_ADDR_W-1:0] addr, logic [63:0] data);
      plan_step_type s;
      s = '{STEP_WRITE, addr, data, '0, 1'b0, '0};
      plan.insert(plan.size(), s);
   endtask

   task automatic plan_row(logic [mlg_pkg::ROW_W-1:0] row, bit typed,
                           mlg_pkg::color_type want);
      plan_step_type s;
      s = '{STEP_ROW, mlg_pkg::CSR_SPARE, '0, row, typed, want};
      plan.insert(plan.size(), s);
   endtask

   // one csr write, plus the same write on the shadow copy
   task automatic write_reg(logic [mlg_pkg::CSR_ADDR_W-1:0] addr, logic [63:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (addr)
         mlg_pkg::CSR_MIDPOINT:   set_midpoint = data[mlg_pkg::MP_W-1:0];
         mlg_pkg::CSR_OPACITY:    set_opacity  = data[mlg_pkg::OPACITY_W-1:0];
         mlg_pkg::CSR_STOP_COUNT: set_count    = data[mlg_pkg::COUNT_W-1:0];
         mlg_pkg::CSR_STOPS_0_1:  set_stops[0] = data;
         mlg_pkg::CSR_STOPS_2_3:  set_stops[1] = data;
         mlg_pkg::CSR_STOPS_4_5:  set_stops[2] = data;
         mlg_pkg::CSR_STOPS_6_7:  set_stops[3] = data;
         default: ;
      endcase
   endtask

   // offer one row, hold it until the transfer, then log what should come out
   task automatic send_row(logic [mlg_pkg::ROW_W-1:0] row, bit typed,
                           mlg_pkg::color_type want);
      int gap;
      row_color_type e;
      gap = idle_gap(req_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= 16'(row);
      do @(posedge clock); while (!req_tready);
      e.row   = row;
      e.color = typed ? want : row_color(row);
      pending_colors.insert(pending_colors.size(), e);
      rows_sent++;
   endtask

   // stop offering and let the pipeline empty before touching registers
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
   endtask

   // a fresh register set, extremes and out-of-range values included
   task automatic randomize_settings();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: v[mlg_pkg::MP_W-1:0] = '0;
         1: v[mlg_pkg::MP_W-1:0] = mlg_pkg::MP_W'(1);
         2: v[mlg_pkg::MP_W-1:0] = mlg_pkg::MP_W'(mlg_pkg::MP_MAX);
         3: v[mlg_pkg::MP_W-1:0] = '1;
         default: ;
      endcase
      write_reg(mlg_pkg::CSR_MIDPOINT, v);

      v = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: v[mlg_pkg::OPACITY_W-1:0] = '0;
         1: v[mlg_pkg::OPACITY_W-1:0] = mlg_pkg::OPACITY_W'(mlg_pkg::OPACITY_MAX);
         2: v[mlg_pkg::OPACITY_W-1:0] = '1;
         default: ;
      endcase
      write_reg(mlg_pkg::CSR_OPACITY, v);

      v = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) begin
         v[mlg_pkg::COUNT_W-1:0] = mlg_pkg::COUNT_W'($urandom_range(1, mlg_pkg::MAX_STOPS));
      end
      write_reg(mlg_pkg::CSR_STOP_COUNT, v);

      for (int r = mlg_pkg::CSR_STOPS_0_1; r <= mlg_pkg::CSR_STOPS_6_7; r++) begin
         v = {$urandom, $urandom};
         case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            default: ;
         endcase
         write_reg(mlg_pkg::CSR_ADDR_W'(r), v);
      end

      if ($urandom_range(0, 3) == 0) write_reg(mlg_pkg::CSR_SPARE, {$urandom, $urandom});
   endtask

   // ---------------------------------------------------------------- result side

   // receiver: random hold-offs, plus one long stall when asked for
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_output) begin
            hold_output = 1'b0;
            n = LONG_HOLD;
         end else begin
            n = idle_gap(rsp_steady);
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // compare every result transfer with the oldest expected color
   task automatic check_color(mlg_pkg::color_type got);
      row_color_type e;
      if (pending_colors.size() == 0) begin
         $display("%0t: result %h with no row pending", $time, got);
         errors++;
      end else begin
         e = pending_colors.pop_front();
         for (int c = 0; c < 4; c++) begin
            if (got[c*CW +: CW] !== e.color[c*CW +: CW]) begin
               $display("%0t: row %0d %s expected %0d actual %0d", $time, e.row,
                        chan_name[c], e.color[c*CW +: CW], got[c*CW +: CW]);
               errors++;
            end
         end
      end
   endtask

   // result check and watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_color(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      int phase;
      int count;

      // directed table: typed colors where the answer is a stop as it stands
      plan_row(9'd0, 1'b1, '0);                      // reset stops are all black
      plan_row(9'd362, 1'b1, '0);
      plan_write(mlg_pkg::CSR_STOPS_0_1, {S1, S0});
      plan_row(9'd0, 1'b1, mlg_pkg::color_type'(S0));    // top row, clamped to start
      plan_row(9'd511, 1'b1, mlg_pkg::color_type'(S1));  // beyond the canvas, clamped to end
      plan_row(9'd362, 1'b1, mlg_pkg::color_type'(S1));
      plan_row(9'd53, 1'b1, mlg_pkg::color_type'(S0));   // last row before the band
      plan_row(9'd54, 1'b0, '0);                     // first row inside the band
      plan_row(9'd180, 1'b0, '0);
      plan_row(9'd308, 1'b0, '0);
      plan_row(9'd309, 1'b1, mlg_pkg::color_type'(S1));  // first row past the band
      plan_write(mlg_pkg::CSR_STOPS_2_3, {S3, S2});
      plan_write(mlg_pkg::CSR_STOPS_4_5, {S5, S4});
      plan_write(mlg_pkg::CSR_STOPS_6_7, {S7, S6});
      plan_write(mlg_pkg::CSR_STOP_COUNT, 64'd15);   // saturates to all eight stops
      plan_row(9'd0, 1'b1, mlg_pkg::color_type'(S0));
      plan_row(9'd511, 1'b1, mlg_pkg::color_type'(S7));
      plan_row(9'd200, 1'b0, '0);
      plan_write(mlg_pkg::CSR_STOP_COUNT, 64'd1);    // single stop, flat color
      plan_row(9'd362, 1'b1, mlg_pkg::color_type'(S0));
      plan_row(9'd0, 1'b1, mlg_pkg::color_type'(S0));
      plan_write(mlg_pkg::CSR_STOP_COUNT, 64'd0);    // zero count acts as one stop
      plan_row(9'd300, 1'b1, mlg_pkg::color_type'(S0));
      plan_write(mlg_pkg::CSR_STOP_COUNT, 64'd2);
      plan_write(mlg_pkg::CSR_MIDPOINT, 64'd0);      // one-row band, hard step
      plan_row(9'd308, 1'b1, mlg_pkg::color_type'(S0));
      plan_row(9'd309, 1'b1, mlg_pkg::color_type'(S1));
      plan_write(mlg_pkg::CSR_MIDPOINT, 64'd127);    // saturates to a full band
      plan_row(9'd54, 1'b0, '0);
      plan_write(mlg_pkg::CSR_OPACITY, 64'd0);       // fully transparent
      plan_row(9'd0, 1'b1, mlg_pkg::color_type'({8'h00, S0[23:0]}));
      plan_write(mlg_pkg::CSR_OPACITY, 64'd511);     // saturates to full opacity
      plan_row(9'd0, 1'b1, mlg_pkg::color_type'(S0));
      plan_write(mlg_pkg::CSR_SPARE, '1);            // address off the map, no effect
      plan_row(9'd0, 1'b1, mlg_pkg::color_type'(S0));
      plan_write(mlg_pkg::CSR_MIDPOINT, 64'd1);      // narrow band of a few rows
      plan_write(mlg_pkg::CSR_OPACITY, 64'd128);
      plan_row(9'd307, 1'b0, '0);
      plan_row(9'd308, 1'b0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == STEP_WRITE) begin
            settle();
            write_reg(plan[i].addr, plan[i].data);
         end else begin
            send_row(plan[i].row, plan[i].typed, plan[i].want);
         end
      end

      // random phases, each under its own register set
      phase     = 0;
      rows_sent = 0;
      while (rows_sent < RANDOM_ROWS) begin
         settle();
         randomize_settings();
         req_steady = (phase % 4 == 1);
         rsp_steady = (phase % 4 == 2);
         if (phase == 3) begin
            // sender keeps pushing while the receiver stalls, fills the pipeline
            req_steady  = 1'b1;
            hold_output = 1'b1;
         end
         count = $urandom_range(60, 160);
         repeat (count) send_row(pick_row(), 1'b0, '0);
         phase++;
      end

      // drain, then give stray results time to show up
      settle();
      repeat (2 * LATENCY) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- multi_stop_linear_gradient_row_color.f -----
src/mlg_pkg.sv
src/mlg_pos.sv
src/mlg_div.sv
src/mlg_blend.sv
src/multi_stop_linear_gradient_row_color.sv
tb/sv/multi_stop_linear_gradient_row_color_tb.sv
